// ===== rtl/k_way_merge_dedup_assert.svh =====
// Assertion macros for the merge block; clk_i and rst_ni must be in scope.
`ifndef K_WAY_MERGE_DEDUP_ASSERT_SVH
`define K_WAY_MERGE_DEDUP_ASSERT_SVH

// Same-cycle implication.
`define KWMD_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kwmd: same-cycle check failed");

// Next-cycle implication.
`define KWMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kwmd: next-cycle check failed");

`endif

// ===== rtl/kwmd_pkg.sv =====
package kwmd_pkg;

  localparam int unsigned LANE_W      = 4;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [CFG_W-1:0] NUM_LANES_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_EMIT,
    ST_ERR
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic apply;
    logic scan_start;
    logic scan_step;
    logic emit_sel;
    logic emit_err;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mismatch;
    logic load_more;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/kwmd_ctrl.sv =====
module kwmd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  kwmd_pkg::sts_t sts_i,
  output kwmd_pkg::cmd_t cmd_o
);
  import kwmd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else if (cfg_we_i) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts_i.mismatch) state_d = ST_ERR;
        else if (sts_i.load_more) state_d = ST_IDLE;
        else state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_ERR: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.load_in = s_tvalid_i;
      end
      ST_APPLY: begin
        cmd_o.apply      = !sts_i.mismatch;
        cmd_o.scan_start = !sts_i.mismatch && !sts_i.load_more;
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_EMIT: cmd_o.emit_sel  = sts_i.out_free;
      ST_ERR:  cmd_o.emit_err  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/kwmd_datapath.sv =====
module kwmd_datapath #(
  parameter int unsigned MAX_LANES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kwmd_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [kwmd_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic                                 s_tuser_i,
  input  kwmd_pkg::cmd_t                       cmd_i,
  output kwmd_pkg::sts_t                       sts_o,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [kwmd_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic [kwmd_pkg::OUT_TUSER_W-1:0]     m_tuser_o
);
  import kwmd_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LANES);
  localparam int unsigned CW0 = $clog2(MAX_LANES + 1);
  localparam int unsigned CW  = (CW0 > CFG_W) ? CW0 : CFG_W;

  // input capture
  logic [LANE_W-1:0] in_lane_q;
  logic [KEY_W-1:0]  in_key_q;
  logic [TAG_W-1:0]  in_tag_q;
  logic              in_ex_q;

  // lane heads
  logic [KEY_W-1:0]     head_key_q [MAX_LANES];
  logic [TAG_W-1:0]     head_tag_q [MAX_LANES];
  logic [MAX_LANES-1:0] active_q, active_d;

  // merge control state
  logic [CFG_W-1:0] nl_q;
  logic [CW-1:0]    loaded_q, loaded_d;
  logic             merging_q, merging_d;
  logic [LW-1:0]    awaited_q, awaited_d;
  logic [KEY_W-1:0] last_key_q, last_key_d;
  logic             have_last_q, have_last_d;

  // scan
  logic [CW-1:0]    idx_q;
  logic             found_q;
  logic [KEY_W-1:0] best_key_q;
  logic [TAG_W-1:0] best_tag_q;
  logic [LW-1:0]    best_idx_q;

  // output register
  logic              m_valid_q;
  logic              out_wv_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [LANE_W-1:0] out_refill_q;
  logic              out_done_q;
  logic              out_err_q;

  logic [CW-1:0] n_lanes;
  logic [CW-1:0] expect_lane;
  logic [CW-1:0] loaded_inc;
  logic [LW-1:0] wr_idx;
  logic [LW-1:0] rd_idx;
  logic          take;
  logic          sel_wr;
  logic          out_free;
  logic          emit;

  always_comb begin
    if (nl_q == '0) begin
      n_lanes = CW'(1);
    end else if (CW'(nl_q) > CW'(MAX_LANES)) begin
      n_lanes = CW'(MAX_LANES);
    end else begin
      n_lanes = CW'(nl_q);
    end
  end

  assign expect_lane = merging_q ? CW'(awaited_q) : loaded_q;
  assign loaded_inc  = loaded_q + CW'(1);
  assign wr_idx      = expect_lane[LW-1:0];
  assign rd_idx      = idx_q[LW-1:0];
  assign take        = active_q[rd_idx] &&
                       (!found_q || ($signed(head_key_q[rd_idx]) < $signed(best_key_q)));
  assign sel_wr      = !have_last_q || (best_key_q != last_key_q);
  assign out_free    = !m_valid_q || m_tready_i;
  assign emit        = cmd_i.emit_sel || cmd_i.emit_err;

  assign sts_o.mismatch  = CW'(in_lane_q) != expect_lane;
  assign sts_o.load_more = !merging_q && (loaded_inc < n_lanes);
  assign sts_o.scan_last = idx_q == (n_lanes - CW'(1));
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_lane_q <= s_tdata_i[LANE_W-1:0];
      in_key_q  <= s_tdata_i[LANE_W +: KEY_W];
      in_tag_q  <= s_tdata_i[LANE_W+KEY_W +: TAG_W];
      in_ex_q   <= s_tuser_i;
    end
    if (cmd_i.apply && !in_ex_q) begin
      head_key_q[wr_idx] <= in_key_q;
      head_tag_q[wr_idx] <= in_tag_q;
    end
    if (cmd_i.scan_step && take) begin
      best_key_q <= head_key_q[rd_idx];
      best_tag_q <= head_tag_q[rd_idx];
      best_idx_q <= rd_idx;
    end
  end

  always_comb begin
    active_d    = active_q;
    loaded_d    = loaded_q;
    merging_d   = merging_q;
    awaited_d   = awaited_q;
    last_key_d  = last_key_q;
    have_last_d = have_last_q;
    if (cmd_i.apply) begin
      active_d[wr_idx] = !in_ex_q;
      if (!merging_q) begin
        loaded_d = loaded_inc;
        if (loaded_inc == n_lanes) merging_d = 1'b1;
      end
    end
    if (cmd_i.emit_sel) begin
      if (found_q) begin
        awaited_d = best_idx_q;
        if (sel_wr) begin
          last_key_d  = best_key_q;
          have_last_d = 1'b1;
        end
      end else begin
        // all lanes drained: back to loading
        active_d    = '0;
        loaded_d    = '0;
        merging_d   = 1'b0;
        awaited_d   = '0;
        last_key_d  = '0;
        have_last_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q        <= NUM_LANES_RST;
      active_q    <= '0;
      loaded_q    <= '0;
      merging_q   <= 1'b0;
      awaited_q   <= '0;
      last_key_q  <= '0;
      have_last_q <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      m_valid_q   <= 1'b0;
    end else if (cfg_we_i) begin
      nl_q        <= cfg_wdata_i;
      active_q    <= '0;
      loaded_q    <= '0;
      merging_q   <= 1'b0;
      awaited_q   <= '0;
      last_key_q  <= '0;
      have_last_q <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      active_q    <= active_d;
      loaded_q    <= loaded_d;
      merging_q   <= merging_d;
      awaited_q   <= awaited_d;
      last_key_q  <= last_key_d;
      have_last_q <= have_last_d;
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + CW'(1);
        if (take) found_q <= 1'b1;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      out_wv_q     <= 1'b0;
      out_key_q    <= '0;
      out_tag_q    <= '0;
      out_refill_q <= LANE_W'(expect_lane);
      out_done_q   <= 1'b0;
      out_err_q    <= 1'b1;
    end else if (cmd_i.emit_sel) begin
      out_wv_q     <= found_q && sel_wr;
      out_key_q    <= found_q ? best_key_q : '0;
      out_tag_q    <= found_q ? best_tag_q : '0;
      out_refill_q <= found_q ? LANE_W'(best_idx_q) : '0;
      out_done_q   <= !found_q;
      out_err_q    <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(OUT_TDATA_W - 1 - KEY_W - TAG_W - LANE_W){1'b0}},
                       out_refill_q, out_tag_q, out_key_q, out_wv_q};
  assign m_tuser_o  = {out_err_q, out_done_q};

  `include "k_way_merge_dedup_assert.svh"

  `KWMD_ASSERT_HOLD(a_merging_fully_loaded, merging_q, loaded_q == n_lanes)
  `KWMD_ASSERT_NEXT(a_done_clears_lanes, cmd_i.emit_sel && !found_q && !cfg_we_i, active_q == '0 && !have_last_q && !merging_q)
  `KWMD_ASSERT_NEXT(a_last_key_follows_write, cmd_i.emit_sel && found_q && sel_wr && !cfg_we_i, last_key_q == out_key_q && out_wv_q)

endmodule

// ===== rtl/k_way_merge_dedup.sv =====
// Result path: an item that completes loading or refills a lane is captured, applied, then
// passes a sequential scan over the n lane heads and the output load; n = num_lanes clamped to 1..16.
// Items are taken one at a time: s_axis_tready is high only while idle, so a refill waits
// for the sequential scan over the lane heads; refills and wrong-lane items also wait for a free output.
// Reset: async active low; returns to loading with all lanes inactive, lane count 16.
// A configuration write restarts the merge in the same way, with the lane count from cfg_wdata_i.
module k_way_merge_dedup #(
  parameter int unsigned MAX_LANES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kwmd_pkg::CFG_W-1:0]           cfg_wdata_i,    // num_lanes
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lane[3:0], key[35:4], payload[67:36], zero pad
  input  logic [kwmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tuser,   // exhausted
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // write_valid[0], out_key[32:1], out_payload[64:33], refill_lane[68:65], zero pad
  output logic [kwmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // done_res[0], protocol_error[1]
  output logic [kwmd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
  import kwmd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kwmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kwmd_datapath #(
    .MAX_LANES (MAX_LANES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
